### sv/mclpd_pkg.sv
package mclpd_pkg;

	localparam logic [1:0] MODE_HEADER  = 2'd0;
	localparam logic [1:0] MODE_PAYLOAD = 2'd1;
	localparam logic [1:0] MODE_DROP    = 2'd2;

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_CLOSE = 1'b1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_ERROR   = 1'b1;

	localparam logic [1:0] HDR_LAST_IDX = 2'd3;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  hdr_count;
		logic [23:0] hdr_partial;
		logic [15:0] remaining;
	} chan_state_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic       last;
		logic [7:0] data;
	} result_t;

endpackage

### sv/mclpd_update.sv
module mclpd_update
	import mclpd_pkg::*;
(
	input  chan_state_t cur,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic [15:0] max_payload,
	output chan_state_t nxt,
	output result_t     res
);

	logic [31:0] len;
	logic        len_bad;
	logic [15:0] rem_dec;

	assign len     = {cur.hdr_partial, data_byte};
	assign len_bad = len[31] || (len == 32'd0) || (len[31:16] != 16'd0)
		|| (len[15:0] > max_payload);
	assign rem_dec = cur.remaining - 16'd1;

	always_comb begin
		nxt = cur;
		res = '0;
		if (op == OP_CLOSE) begin
			nxt = '0;
		end else begin
			case (cur.mode)
				MODE_DROP: begin
					nxt = cur;
				end
				MODE_PAYLOAD: begin
					res.valid = 1'b1;
					res.kind  = KIND_PAYLOAD;
					res.data  = data_byte;
					if (rem_dec == 16'd0) begin
						res.last = 1'b1;
						nxt      = '0;
					end else begin
						nxt.remaining = rem_dec;
					end
				end
				default: begin
					// Header phase; the unused mode code behaves the same way.
					if (cur.hdr_count != HDR_LAST_IDX) begin
						nxt.hdr_partial = {cur.hdr_partial[15:0], data_byte};
						nxt.hdr_count   = cur.hdr_count + 2'd1;
					end else begin
						nxt.hdr_count   = 2'd0;
						nxt.hdr_partial = 24'd0;
						if (len_bad) begin
							nxt.mode      = MODE_DROP;
							nxt.remaining = 16'd0;
							res.valid     = 1'b1;
							res.kind      = KIND_ERROR;
						end else begin
							nxt.mode      = MODE_PAYLOAD;
							nxt.remaining = len[15:0];
						end
					end
				end
			endcase
		end
	end

endmodule

### sv/multi_channel_length_prefix_deframer.sv
// Multi-channel length-prefixed deframer.
// Input stream: s_tdata = {data_byte[11:4], channel[3:0]}, s_tuser = op (1 closes the
// channel). Each channel collects a 4-byte big-endian length; a length of 1 to
// max_payload then forwards that many bytes, the final one with m_tlast set. Any other
// length gives one error item (m_tuser = 1) and the channel drops bytes until closed.
// Output stream: m_tdata = {payload_byte[11:4], out_channel[3:0]}, m_tuser = kind.
// Configuration: cfg_data is max_payload, written when cfg_valid is high (always ready).
// Throughput is one item per cycle while the output is not stalled. Per-channel state
// sits in a synchronous memory read at acceptance and written back as the item leaves
// stage 1; a forwarding register covers a write and read of the same channel at the
// same edge. Results pass the stage 1 and output registers. When the receiver stalls, the
// output register holds and the stage behind it stalls too, so s_tready drops after at
// most one more item. Reset clears all channel valid bits at once, so every channel
// starts in the header phase with no clearing pass; max_payload returns to 1024.
module multi_channel_length_prefix_deframer
	import mclpd_pkg::*;
#(
	parameter int CHANNELS = 16
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // channel[3:0], data_byte[11:4], zero pad
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_channel[3:0], payload_byte[11:4], zero pad
	output logic        m_tuser,   // kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [8:0] CH_LIM = 9'(CHANNELS);

	logic [15:0] max_payload_q;

	chan_state_t mem_q [CHANNELS];
	logic [CHANNELS-1:0] written_q;

	logic [8:0]       in_chan_ext;
	logic [IDX_W-1:0] rd_idx;
	logic             in_range;
	logic             in_accept;

	logic             valid_s1;
	logic             op_s1;
	logic [7:0]       byte_s1;
	logic [3:0]       chan_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             range_s1;
	logic             rd_ok_s1;
	chan_state_t      rdata_s1;

	logic             fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	chan_state_t      fwd_data_q;

	chan_state_t cur_state;
	chan_state_t nxt_state;
	result_t     res;
	logic        adv_s1;
	logic        wr_en;

	logic       out_valid_q;
	logic       out_kind_q;
	logic       out_last_q;
	logic [3:0] out_chan_q;
	logic [7:0] out_byte_q;

	assign in_chan_ext = {5'd0, s_tdata[3:0]};
	assign rd_idx      = in_chan_ext[IDX_W-1:0];
	assign in_range    = in_chan_ext < CH_LIM;

	assign adv_s1    = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign in_accept = s_tvalid && s_tready;
	assign wr_en     = adv_s1 && range_s1;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (fwd_valid_q && (fwd_idx_q == idx_s1)) begin
			cur_state = fwd_data_q;
		end else if (rd_ok_s1) begin
			cur_state = rdata_s1;
		end else begin
			cur_state = '0;
		end
	end

	mclpd_update u_update (
		.cur         (cur_state),
		.op          (op_s1),
		.data_byte   (byte_s1),
		.max_payload (max_payload_q),
		.nxt         (nxt_state),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid) begin
			max_payload_q <= cfg_data;
		end
	end

	// State memory: read at acceptance, written back from stage 1.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_s1] <= nxt_state;
		end
		if (in_accept) begin
			rdata_s1 <= mem_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1    <= 1'b1;
				fwd_valid_q <= wr_en;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1      <= s_tuser;
			byte_s1    <= s_tdata[11:4];
			chan_s1    <= s_tdata[3:0];
			idx_s1     <= rd_idx;
			range_s1   <= in_range;
			rd_ok_s1   <= written_q[rd_idx];
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= nxt_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= range_s1 && res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_kind_q <= res.kind;
			out_last_q <= res.last;
			out_chan_q <= chan_s1;
			out_byte_q <= res.data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_byte_q, out_chan_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

### sv/mclpd_checker.sv
module mclpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_stall_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped during stall");

	a_stall_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output item changed during stall");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[15:4] == 12'd0) && !m_tlast)
		else $error("error item carries payload or last");

	// A fresh result after an idle output always traces back to an accepted input item.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching accepted item");

endmodule

bind multi_channel_length_prefix_deframer mclpd_checker u_mclpd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
